@@ rtl/spsc_pkg.sv @@
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared constants and types for the stack pop sequence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spsc_pkg;

	localparam int CNT_W         = 11;
	localparam int MAX_ITEMS_DEF = 1024;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spsc_cell.sv @@
// ----------------------------------------------------------------------------
// spsc_cell
// One stack entry; takes the upper neighbor on push, the lower one on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_cell
	import spsc_pkg::*;
#(
	parameter int VW = 10
) (
	input  wire logic          clk,
	input  wire stk_ctrl_t     ctrl,
	input  wire logic [VW-1:0] upper,
	input  wire logic [VW-1:0] lower,
	output logic      [VW-1:0] value
);

	logic [VW-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			value_q <= upper;
		end else if (ctrl.pop) begin
			value_q <= lower;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

@@ rtl/spsc_stack.sv @@
// ----------------------------------------------------------------------------
// spsc_stack
// Shift-register stack built as a chain of cells; cell zero is the top.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_stack
	import spsc_pkg::*;
#(
	parameter int DEPTH = MAX_ITEMS_DEF,
	parameter int VW    = 10
) (
	input  wire logic          clk,
	input  wire stk_ctrl_t     ctrl,
	input  wire logic [VW-1:0] push_data,
	output logic      [VW-1:0] top
);

	logic [VW-1:0] cell_val [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VW-1:0] up_d;
		logic [VW-1:0] dn_d;

		if (i == 0) begin : g_top
			assign up_d = push_data;
		end else begin : g_mid
			assign up_d = cell_val[i-1];
		end

		if (i == DEPTH-1) begin : g_bot
			assign dn_d = cell_val[i];
		end else begin : g_inner
			assign dn_d = cell_val[i+1];
		end

		spsc_cell #(
			.VW(VW)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.upper(up_d),
			.lower(dn_d),
			.value(cell_val[i])
		);
	end

	assign top = cell_val[0];

endmodule

`default_nettype wire

@@ rtl/stack_pop_sequence_check.sv @@
// ----------------------------------------------------------------------------
// stack_pop_sequence_check
// Decides whether a target sequence can come out of 1..N sent through one
// stack; answers on the beat flagged last.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    target_value, is_last
//  out      out  out_valid/out_stall  feasible
//  cfg      in   cfg_valid/cfg_ready  train_count
//
//  a beat that passes through or pops is accepted and then checked; a beat that
//  runs into the cell chain is accepted, checked and then pushes values in turn
//  until its target comes up or the sequence fails
//  a last beat waits in ST_FINISH while a previous result is still stalled
//  reset clears the sequence state and sets the stored count to 1; no clearing pass
//  in_stall is high while a beat is at work
//
`default_nettype none

module stack_pop_sequence_check
	import spsc_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [CNT_W-1:0] target_value,
	input  wire logic             is_last,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  feasible,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] train_count
);

	localparam int VW   = $clog2(MAX_ITEMS + 1);
	localparam int DW   = $clog2(MAX_ITEMS + 1);
	localparam int NW   = ((CNT_W + 1) > $clog2(MAX_ITEMS + 2)) ? (CNT_W + 1) :
		$clog2(MAX_ITEMS + 2);
	localparam int CMPW = ((NW > CNT_W) ? NW : CNT_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PUSH,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [NW-1:0]    next_q;
	logic [DW-1:0]    depth_q;
	logic             failed_q;
	logic [CNT_W-1:0] want_q;
	logic             last_q;
	logic             out_valid_q;
	logic             feasible_q;

	logic [VW-1:0]    top;
	stk_ctrl_t        stk_ctrl;

	logic [CMPW-1:0]  n_lim;
	logic [CMPW-1:0]  next_w;
	logic [CMPW-1:0]  want_w;
	logic [CMPW-1:0]  top_w;
	logic             done;
	logic             fail_set;
	logic             inc_next;
	logic             can_finish;
	logic             seq_end;

	assign n_lim  = (CMPW'(count_q) > CMPW'(MAX_ITEMS)) ? CMPW'(MAX_ITEMS) : CMPW'(count_q);
	assign next_w = CMPW'(next_q);
	assign want_w = CMPW'(want_q);
	assign top_w  = CMPW'(top);

	always_comb begin
		done          = 1'b0;
		fail_set      = 1'b0;
		inc_next      = 1'b0;
		stk_ctrl.push = 1'b0;
		stk_ctrl.pop  = 1'b0;
		case (state_q)
			ST_CHECK: begin
				if (failed_q) begin
					done = 1'b1;
				end else if (next_w == want_w) begin
					inc_next = 1'b1;
					done     = 1'b1;
				end else if (depth_q != '0 && top_w == want_w) begin
					stk_ctrl.pop = 1'b1;
					done         = 1'b1;
				end
			end
			ST_PUSH: begin
				if (next_w <= n_lim) begin
					if (next_w == want_w) begin
						inc_next = 1'b1;
						done     = 1'b1;
					end else if (depth_q >= DW'(MAX_ITEMS)) begin
						fail_set = 1'b1;
						done     = 1'b1;
					end else begin
						stk_ctrl.push = 1'b1;
						inc_next      = 1'b1;
					end
				end else begin
					fail_set = 1'b1;
					done     = 1'b1;
				end
			end
			ST_FINISH: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	assign can_finish = !last_q || !out_valid_q || !out_stall;
	assign seq_end    = done && can_finish && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= CNT_W'(1);
			next_q      <= NW'(1);
			depth_q     <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			feasible_q  <= 1'b0;
			want_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				count_q <= train_count;
			end
			if (seq_end) begin
				out_valid_q <= 1'b1;
				feasible_q  <= !(failed_q || fail_set);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (seq_end) begin
				next_q <= NW'(1);
			end else if (inc_next) begin
				next_q <= next_q + NW'(1);
			end
			if (seq_end) begin
				depth_q <= '0;
			end else if (stk_ctrl.push) begin
				depth_q <= depth_q + DW'(1);
			end else if (stk_ctrl.pop) begin
				depth_q <= depth_q - DW'(1);
			end
			if (seq_end) begin
				failed_q <= 1'b0;
			end else if (fail_set) begin
				failed_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						want_q  <= target_value;
						last_q  <= is_last;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK, ST_PUSH, ST_FINISH: begin
					if (done) begin
						if (can_finish) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FINISH;
						end
					end else if (state_q == ST_CHECK) begin
						state_q <= ST_PUSH;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	spsc_stack #(
		.DEPTH(MAX_ITEMS),
		.VW   (VW)
	) u_stack (
		.clk      (clk),
		.ctrl     (stk_ctrl),
		.push_data(VW'(next_q)),
		.top      (top)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign feasible  = feasible_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ tb/sv/stack_pop_sequence_check_tb.sv @@
// ----------------------------------------------------------------------------
// stack_pop_sequence_check_tb
// Drives target sequences into the stack pop sequence checker and compares
// every feasible beat with a cycle-free stack replay kept in the bench.
// A short table covers the corner cases, then random sequences (mostly legal
// stack orders, some broken) run under three idle patterns and several counts.
// ----------------------------------------------------------------------------
module stack_pop_sequence_check_tb;
	import spsc_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int TIMEOUT_CYC = 2_000_000;
	localparam int SETTLE_CYC  = 3 * MAX_ITEMS_DEF + 16;
	localparam int HOLD_CYC    = 400;
	localparam int SEG_BEATS   = 103;
	localparam int PLAN_LEN    = 28;

	typedef enum logic {ROW_BEAT, ROW_COUNT} row_kind_t;
	typedef enum logic [1:0] {ANS_OPEN, ANS_NO, ANS_YES} ans_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] value;
		logic             last;
		ans_t             ans;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [CNT_W-1:0] target_value;
	logic             is_last;
	logic             out_valid;
	logic             out_stall;
	logic             feasible;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] train_count;

	int send_idle_pct;
	int stall_pct;
	bit hold_now;
	int mismatches;

	// stack replay state
	logic [CNT_W-1:0] n_setting;
	int               next_num;
	int               depth;
	bit               seq_failed;
	int               stk_vals [MAX_ITEMS_DEF];
	bit               feasible_due [$];
	int               seq_vals [$];

	row_t plan [0:PLAN_LEN-1] = '{
		'{ROW_BEAT,  11'd1,    1'b1, ANS_YES},
		'{ROW_COUNT, 11'd0,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1,    1'b1, ANS_YES},
		'{ROW_COUNT, 11'd3,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd3,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd2,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1,    1'b1, ANS_YES},
		'{ROW_BEAT,  11'd3,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd2,    1'b1, ANS_NO},
		'{ROW_BEAT,  11'd0,    1'b1, ANS_NO},
		'{ROW_BEAT,  11'd4,    1'b1, ANS_NO},
		'{ROW_BEAT,  11'd2,    1'b1, ANS_YES},
		'{ROW_BEAT,  11'd1,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd2,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd3,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1,    1'b1, ANS_NO},
		'{ROW_COUNT, 11'd2047, 1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1024, 1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1023, 1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1024, 1'b1, ANS_NO},
		'{ROW_COUNT, 11'd1024, 1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1024, 1'b1, ANS_YES},
		'{ROW_COUNT, 11'd5,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd2,    1'b0, ANS_OPEN},
		'{ROW_COUNT, 11'd1,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd1,    1'b0, ANS_OPEN},
		'{ROW_BEAT,  11'd3,    1'b1, ANS_OPEN}
	};

	stack_pop_sequence_check #(
		.MAX_ITEMS(MAX_ITEMS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_value(target_value),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.feasible(feasible),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.train_count(train_count)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	function automatic void advance_stack(int want);
		int n;
		n = (int'(n_setting) > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : int'(n_setting);
		if (seq_failed)
			return;
		if (next_num == want) begin
			next_num++;
			return;
		end
		if (depth > 0 && stk_vals[depth-1] == want) begin
			depth--;
			return;
		end
		while (next_num <= n) begin
			if (next_num == want) begin
				next_num++;
				return;
			end
			if (depth >= MAX_ITEMS_DEF) begin
				seq_failed = 1'b1;
				return;
			end
			stk_vals[depth] = next_num;
			depth++;
			next_num++;
		end
		seq_failed = 1'b1;
	endfunction

	function automatic void replay_target(int want, bit last, ans_t ans);
		advance_stack(want);
		if (last) begin
			if (ans == ANS_OPEN)
				feasible_due.push_back(!seq_failed);
			else
				feasible_due.push_back(ans == ANS_YES);
			next_num   = 1;
			depth      = 0;
			seq_failed = 1'b0;
		end
	endfunction

	task automatic offer_target(int v, bit last, ans_t ans);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid     <= 1'b1;
		target_value <= v[CNT_W-1:0];
		is_last      <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		replay_target(v, last, ans);
	endtask

	task automatic await_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (feasible_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_train_count(int v);
		await_drain();
		// a sequence may still be open, so let any push run finish
		repeat (SETTLE_CYC)
			@(posedge clk);
		cfg_valid   <= 1'b1;
		train_count <= v[CNT_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_setting = v[CNT_W-1:0];
	endtask

	// mostly legal stack orders, sometimes mutated or plain noise
	task automatic build_sequence(int n_cfg);
		int n_eff;
		int len;
		int g_next;
		int span;
		int jump;
		int i;
		int k;
		int a;
		int b;
		int tmp;
		int gstk [$];
		n_eff = (n_cfg > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : n_cfg;
		seq_vals.delete();
		if (n_eff == 0 || $urandom_range(9) == 0) begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++)
				seq_vals.push_back($urandom_range(0, MAX_ITEMS_DEF));
			return;
		end
		if (n_eff <= 40 && $urandom_range(3) != 0)
			len = n_eff;
		else
			len = $urandom_range(1, (n_eff < 24) ? n_eff : 24);
		g_next = 1;
		for (i = 0; i < len; i++) begin
			if (gstk.size() != 0 && (g_next > n_eff || $urandom_range(1) == 0)) begin
				seq_vals.push_back(gstk.pop_back());
			end else begin
				span = n_eff - g_next;
				if ($urandom_range(7) == 0)
					jump = $urandom_range(0, span);
				else
					jump = $urandom_range(0, (span < 3) ? span : 3);
				for (k = 0; k < jump; k++)
					gstk.push_back(g_next + k);
				seq_vals.push_back(g_next + jump);
				g_next += jump + 1;
			end
		end
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(2))
				0: seq_vals[$urandom_range(0, len - 1)] = $urandom_range(0, MAX_ITEMS_DEF);
				1: begin
					tmp = (n_eff < MAX_ITEMS_DEF) ? n_eff + 1 : MAX_ITEMS_DEF;
					repeat ($urandom_range(1, 3))
						seq_vals.push_back($urandom_range(1, tmp));
				end
				default: begin
					a = $urandom_range(0, len - 1);
					b = $urandom_range(0, len - 1);
					tmp = seq_vals[a];
					seq_vals[a] = seq_vals[b];
					seq_vals[b] = tmp;
				end
			endcase
		end
	endtask

	task automatic run_segment(int n_cfg, int goal);
		int sent;
		int i;
		sent = 0;
		while (sent < goal) begin
			build_sequence(n_cfg);
			for (i = 0; i < seq_vals.size(); i++)
				offer_target(seq_vals[i], i == seq_vals.size() - 1, ANS_OPEN);
			sent += seq_vals.size();
			if ($urandom_range(24) == 0)
				await_drain();
		end
	endtask

	// receiver: random stall, or one long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC)
					@(posedge clk);
				hold_now = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic want_f;
		if (arst_n && out_valid && !out_stall) begin
			if (feasible_due.size() == 0) begin
				$error("feasible: expected no beat, got %0b", feasible);
				mismatches++;
			end else begin
				want_f = feasible_due.pop_front();
				if (feasible !== want_f) begin
					$error("feasible: expected %0b, got %0b", want_f, feasible);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_CYC * CLK_PERIOD);
		$display("stack_pop_sequence_check_tb: errors");
		$finish;
	end

	initial begin
		int r;
		int ph;
		int sg;
		int cnt;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		target_value  <= '0;
		is_last       <= 1'b0;
		cfg_valid     <= 1'b0;
		train_count   <= '0;
		send_idle_pct = 35;
		stall_pct     = 73;
		hold_now      = 1'b0;
		mismatches    = 0;
		n_setting     = 1;
		next_num      = 1;
		depth         = 0;
		seq_failed    = 1'b0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].kind == ROW_COUNT)
				load_train_count(int'(plan[r].value));
			else
				offer_target(int'(plan[r].value), plan[r].last, plan[r].ans);
		end

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 35;
					stall_pct     = 73;
				end
				1: begin
					send_idle_pct = 73;
					stall_pct     = 35;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			for (sg = 0; sg < 6; sg++) begin
				case (sg)
					0: cnt = $urandom_range(3, 8);
					1: cnt = (ph == 1) ? 2047 : MAX_ITEMS_DEF;
					2: cnt = $urandom_range(9, 40);
					3: cnt = ph;
					4: cnt = $urandom_range(41, MAX_ITEMS_DEF);
					default: cnt = $urandom_range(2, 6);
				endcase
				load_train_count(cnt);
				// long receiver hold while beats keep coming
				if (ph == 0 && sg == 0)
					hold_now = 1'b1;
				run_segment(cnt, SEG_BEATS);
			end
		end

		await_drain();
		repeat (SETTLE_CYC)
			@(posedge clk);
		if (mismatches == 0)
			$display("stack_pop_sequence_check_tb: clean");
		else
			$display("stack_pop_sequence_check_tb: errors");
		$finish;
	end

endmodule

@@ stack_pop_sequence_check.f @@
rtl/spsc_pkg.sv
rtl/spsc_cell.sv
rtl/spsc_stack.sv
rtl/stack_pop_sequence_check.sv
tb/sv/stack_pop_sequence_check_tb.sv
